### design/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

  localparam int DATA_W      = 28;
  localparam int FREE_LEFT_W = 13;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = 5;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] DATA_START_RST = DATA_W'(359);
  localparam logic [DATA_W-1:0] LOW_LIMIT_RST  = DATA_W'(100);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_FREED     = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_ISSUE,
    S_A_CHECK,
    S_F_CALC,
    S_F_READ,
    S_F_TEST,
    S_DONE
  } state_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [DATA_W-1:0] freed_block;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]      granted_block;
    status_t                status;
    logic [FREE_LEFT_W-1:0] free_left;
  } out_item_t;

endpackage

### design/bba_bitmap_ram.sv
// Word-wide bitmap storage: one write port, one registered read port.
module bba_bitmap_ram #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [bba_pkg::WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [bba_pkg::WORD_W-1:0] rdata
);

  logic [bba_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bba_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/bba_word_scan.sv
// Finds the lowest clear bit of one map word.
module bba_word_scan (
  input  logic [bba_pkg::WORD_W-1:0] word,
  output logic                       found,
  output logic [bba_pkg::BIT_W-1:0]  bit_idx
);

  always_comb begin
    found   = ~&word;
    bit_idx = '0;
    // walk down so the lowest clear bit wins
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        bit_idx = bba_pkg::BIT_W'(i);
      end
    end
  end

endmodule

### design/bitmap_block_allocator.sv
// Bitmap block allocator: first-fit allocation and release over a map of NUM_BLOCKS blocks.
// The map lives in a RAM of 32-bit words; a scan pointer marks the lowest word that may
// still hold a clear bit (every word below it is full), so an allocate normally reads a
// single word, plus one more word for every full word skipped past the pointer. A free
// does a bounds check, a word read, a bit test and a write back. One item is worked on
// at a time; the next is accepted while a result still waits on the output register.
// After reset the map RAM is cleared word by word before the first item is taken;
// configuration writes are accepted at any time.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bba_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bba_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::DATA_W-1:0]    cfg_data
);

  localparam int WORD_W     = bba_pkg::WORD_W;
  localparam int BIT_W      = bba_pkg::BIT_W;
  localparam int DATA_W     = bba_pkg::DATA_W;
  localparam int FL_W       = bba_pkg::FREE_LEFT_W;
  localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WAW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CW         = $clog2(NUM_BLOCKS + 1);
  localparam int LAST_VALID = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(NUM_WORDS - 1);
  // bits past the end of the map read as taken
  localparam logic [WORD_W-1:0] PAD_MASK =
    (LAST_VALID == WORD_W) ? '0 : ({WORD_W{1'b1}} << LAST_VALID);

  bba_pkg::state_t    state_r, state_nxt;
  logic [WAW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [WAW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [DATA_W-1:0]  ds_r, low_r;
  logic               out_valid_r, out_valid_nxt;

  bba_pkg::in_item_t  in_r;
  logic               below_r, below_nxt;
  logic [DATA_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0]  res_granted_r, res_granted_nxt;
  bba_pkg::status_t   res_status_r, res_status_nxt;
  bba_pkg::out_item_t out_data_r, out_data_nxt;

  logic               mem_we;
  logic [WAW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata;
  logic [WORD_W-1:0]  scan_word;
  logic               scan_found;
  logic [BIT_W-1:0]   scan_bit;
  logic [WAW-1:0]     free_word;
  logic [BIT_W-1:0]   free_bit;
  logic [CW+FL_W-1:0] cnt_ext;

  bba_bitmap_ram #(
    .DEPTH  (NUM_WORDS),
    .ADDR_W (WAW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign scan_word = mem_rdata | ((ptr_r == LAST_WORD) ? PAD_MASK : '0);

  bba_word_scan u_scan (
    .word    (scan_word),
    .found   (scan_found),
    .bit_idx (scan_bit)
  );

  assign free_word = idx_r[BIT_W +: WAW];
  assign free_bit  = idx_r[BIT_W-1:0];
  assign cnt_ext   = (CW + FL_W)'(count_r);

  assign in_ready  = (state_r == bba_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    ptr_nxt         = ptr_r;
    count_nxt       = count_r;
    below_nxt       = below_r;
    idx_nxt         = idx_r;
    res_granted_nxt = res_granted_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    mem_we          = 1'b0;
    mem_waddr       = ptr_r;
    mem_wdata       = '0;
    mem_raddr       = ptr_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = bba_pkg::S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      bba_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.opcode == bba_pkg::OP_ALLOC) ? bba_pkg::S_A_ISSUE
                                                             : bba_pkg::S_F_CALC;
        end
      end
      bba_pkg::S_A_ISSUE: begin
        res_granted_nxt = '0;
        if (count_r == '0) begin
          res_status_nxt = bba_pkg::ST_NO_SPACE;
          state_nxt      = bba_pkg::S_DONE;
        end else begin
          mem_raddr = ptr_r;
          state_nxt = bba_pkg::S_A_CHECK;
        end
      end
      bba_pkg::S_A_CHECK: begin
        if (scan_found) begin
          mem_we          = 1'b1;
          mem_waddr       = ptr_r;
          mem_wdata       = mem_rdata | (WORD_W'(1) << scan_bit);
          count_nxt       = count_r - 1'b1;
          res_granted_nxt = ds_r + DATA_W'({ptr_r, scan_bit});
          res_status_nxt  = bba_pkg::ST_ALLOCATED;
          state_nxt       = bba_pkg::S_DONE;
        end else if (ptr_r == LAST_WORD) begin
          res_granted_nxt = '0;
          res_status_nxt  = bba_pkg::ST_NO_SPACE;
          state_nxt       = bba_pkg::S_DONE;
        end else begin
          // word is full: step on, reading the next word for the coming cycle
          ptr_nxt   = ptr_r + 1'b1;
          mem_raddr = ptr_r + 1'b1;
        end
      end
      bba_pkg::S_F_CALC: begin
        below_nxt = (in_r.freed_block < low_r) || (in_r.freed_block < ds_r);
        idx_nxt   = in_r.freed_block - ds_r;
        state_nxt = bba_pkg::S_F_READ;
      end
      bba_pkg::S_F_READ: begin
        res_granted_nxt = '0;
        if (below_r || (idx_r >= DATA_W'(NUM_BLOCKS))) begin
          res_status_nxt = bba_pkg::ST_IGNORED;
          state_nxt      = bba_pkg::S_DONE;
        end else begin
          mem_raddr = free_word;
          state_nxt = bba_pkg::S_F_TEST;
        end
      end
      bba_pkg::S_F_TEST: begin
        if (mem_rdata[free_bit]) begin
          mem_we    = 1'b1;
          mem_waddr = free_word;
          mem_wdata = mem_rdata & ~(WORD_W'(1) << free_bit);
          if (count_r < CW'(NUM_BLOCKS)) begin
            count_nxt = count_r + 1'b1;
          end
          if (free_word < ptr_r) begin
            ptr_nxt = free_word;
          end
          res_status_nxt = bba_pkg::ST_FREED;
        end else begin
          res_status_nxt = bba_pkg::ST_IGNORED;
        end
        state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.granted_block = res_granted_r;
          out_data_nxt.status        = res_status_r;
          out_data_nxt.free_left     = cnt_ext[FL_W-1:0];
          state_nxt                  = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      ptr_r       <= '0;
      count_r     <= CW'(NUM_BLOCKS);
      out_valid_r <= 1'b0;
      ds_r        <= bba_pkg::DATA_START_RST;
      low_r       <= bba_pkg::LOW_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          bba_pkg::REG_DATA_START: ds_r  <= cfg_data;
          bba_pkg::REG_LOW_LIMIT:  low_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    below_r       <= below_nxt;
    idx_r         <= idx_nxt;
    res_granted_r <= res_granted_nxt;
    res_status_r  <= res_status_nxt;
    out_data_r    <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(NUM_BLOCKS))
    else $error("free count above map size");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_CLEAR) |-> !in_ready)
    else $error("item accepted during map clear");

  a_grant_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_A_CHECK && scan_found) |=> (count_r == $past(count_r) - 1'b1))
    else $error("grant did not lower free count");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_IDLE || state_r == bba_pkg::S_DONE) |-> !mem_we)
    else $error("map write outside an operation");

  a_nospace_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != bba_pkg::ST_ALLOCATED)
      |-> (out_data_r.granted_block == '0))
    else $error("nonzero block on a result without a grant");

endmodule
